// ===== design/trm_pkg.sv =====
package trm_pkg;

  // Field widths fixed by the instruction and result formats
  localparam int unsigned OP_W     = 5;
  localparam int unsigned REG_W    = 3;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned PC_OUT_W = 8;
  localparam int unsigned STAT_W   = 3;

  // Default sizes
  localparam int unsigned INSTR_DEPTH_DEF = 128;
  localparam int unsigned DATA_DEPTH_DEF  = 1024;
  localparam int unsigned REG_COUNT_DEF   = 8;

  typedef enum logic [OP_W-1:0] {
    OP_HALT  = 5'd0,
    OP_IN    = 5'd1,
    OP_OUT   = 5'd2,
    OP_ADD   = 5'd3,
    OP_SUB   = 5'd4,
    OP_MUL   = 5'd5,
    OP_DIV   = 5'd6,
    OP_LD    = 5'd7,
    OP_ST    = 5'd8,
    OP_LDA   = 5'd9,
    OP_LDC   = 5'd10,
    OP_JLT   = 5'd11,
    OP_JLE   = 5'd12,
    OP_JGE   = 5'd13,
    OP_JGT   = 5'd14,
    OP_JEQ   = 5'd15,
    OP_JNE   = 5'd16,
    OP_NOP   = 5'd17,
    OP_EMPTY = 5'd18
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 3'd0,
    ST_HALT    = 3'd1,
    ST_DIV0    = 3'd2,
    ST_ADDR    = 3'd3,
    ST_JUMP    = 3'd4,
    ST_EMPTY   = 3'd5,
    ST_STOPPED = 3'd6
  } status_e;

  // Controller to datapath
  typedef struct packed {
    logic capture;     // latch instruction, read register file
    logic exec;        // evaluate and commit pc / flag / simple writes
    logic ld_commit;   // write load data to register
    logic div_commit;  // write quotient to register
    logic out_load;    // move result to output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_done;
    logic go_mem;
    logic go_div;
    logic div_done;
  } stat_t;

endpackage

// ===== design/trm_if.sv =====
interface trm_in_if;
  logic                           valid;
  logic                           ready;
  logic [trm_pkg::OP_W-1:0]       operation;
  logic [trm_pkg::REG_W-1:0]      dest_reg;
  logic [trm_pkg::REG_W-1:0]      src_a_reg;
  logic [trm_pkg::REG_W-1:0]      src_b_reg;
  logic signed [trm_pkg::WORD_W-1:0] immediate;
  logic signed [trm_pkg::WORD_W-1:0] input_value;

  modport source (output valid, operation, dest_reg, src_a_reg, src_b_reg, immediate,
                  input_value, input ready);
  modport sink   (input valid, operation, dest_reg, src_a_reg, src_b_reg, immediate,
                  input_value, output ready);
endinterface

interface trm_out_if;
  logic                              valid;
  logic                              ready;
  logic [trm_pkg::PC_OUT_W-1:0]      next_pc;
  logic                              halted;
  logic [trm_pkg::STAT_W-1:0]        status;
  logic                              out_valid;
  logic signed [trm_pkg::WORD_W-1:0] out_value;

  modport source (output valid, next_pc, halted, status, out_valid, out_value, input ready);
  modport sink   (input valid, next_pc, halted, status, out_valid, out_value, output ready);
endinterface

// ===== design/tiny_register_machine_step_core.sv =====
// Channel   Dir  Handshake      Payload
// in_ch     in   valid / ready  operation, dest_reg, src_a_reg, src_b_reg, immediate,
//                               input_value
// out_ch    out  valid / ready  next_pc, halted, status, out_valid, out_value
//
// One instruction at a time: capture, execute, then response for most operations; LD
// adds a registered data memory read, DIV the divider (one quotient bit per cycle).
// After reset the data memory is swept to zero with in_ch.ready low.
// A finished result sits in the output register; the next instruction is accepted
// while it waits, and is held before its own result until out_ch.ready frees the slot.
module tiny_register_machine_step_core #(
  parameter int unsigned INSTR_DEPTH = trm_pkg::INSTR_DEPTH_DEF,
  parameter int unsigned DATA_DEPTH  = trm_pkg::DATA_DEPTH_DEF,
  parameter int unsigned REG_COUNT   = trm_pkg::REG_COUNT_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  trm_in_if.sink     in_ch,
  trm_out_if.source  out_ch
);
  trm_pkg::cmd_t  cmd;
  trm_pkg::stat_t stat;

  trm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ch.ready),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  trm_datapath #(
    .INSTR_DEPTH (INSTR_DEPTH),
    .DATA_DEPTH  (DATA_DEPTH),
    .REG_COUNT   (REG_COUNT)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .operation_i   (in_ch.operation),
    .dest_reg_i    (in_ch.dest_reg),
    .src_a_reg_i   (in_ch.src_a_reg),
    .src_b_reg_i   (in_ch.src_b_reg),
    .immediate_i   (in_ch.immediate),
    .input_value_i (in_ch.input_value),
    .next_pc_o     (out_ch.next_pc),
    .halted_o      (out_ch.halted),
    .status_o      (out_ch.status),
    .out_valid_o   (out_ch.out_valid),
    .out_value_o   (out_ch.out_value)
  );
endmodule

// ===== design/trm_div.sv =====
module trm_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [trm_pkg::WORD_W-1:0]    dividend_i,
  input  logic [trm_pkg::WORD_W-1:0]    divisor_i,
  output logic                          done_o,
  output logic [trm_pkg::WORD_W-1:0]    quotient_o
);
  localparam int unsigned W  = trm_pkg::WORD_W;
  localparam int unsigned CW = $clog2(W);

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [W-1:0]  rem_q, quo_q, den_q;
  logic          neg_q;
  logic [W:0]    shifted;
  logic          fits;

  // one quotient bit per cycle, restoring
  assign shifted = {rem_q, quo_q[W-1]};
  assign fits    = shifted >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // magnitudes in, sign fixed at the end
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i[W-1] ? (~dividend_i + 1'b1) : dividend_i;
      den_q <= divisor_i[W-1] ? (~divisor_i + 1'b1) : divisor_i;
      neg_q <= dividend_i[W-1] ^ divisor_i[W-1];
    end else if (busy_q) begin
      rem_q <= fits ? W'(shifted - {1'b0, den_q}) : shifted[W-1:0];
      quo_q <= {quo_q[W-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? (~quo_q + 1'b1) : quo_q;
endmodule

// ===== design/trm_ctrl.sv =====
module trm_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  trm_pkg::stat_t stat_i,
  output trm_pkg::cmd_t  cmd_o
);
  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_EXEC, S_MEM, S_DIV, S_RESP
  } state_e;

  state_e state_q;
  logic   out_v_q;

  // command decode
  always_comb begin
    cmd_o            = '0;
    cmd_o.capture    = (state_q == S_IDLE) && in_valid_i;
    cmd_o.exec       = (state_q == S_EXEC);
    cmd_o.ld_commit  = (state_q == S_MEM);
    cmd_o.div_commit = (state_q == S_DIV) && stat_i.div_done;
    cmd_o.out_load   = (state_q == S_RESP) && (!out_v_q || out_ready_i);
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      out_v_q <= 1'b0;
    end else begin
      if (cmd_o.out_load) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          if (stat_i.clr_done) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid_i) state_q <= S_EXEC;
        end
        S_EXEC: begin
          if (stat_i.go_mem)      state_q <= S_MEM;
          else if (stat_i.go_div) state_q <= S_DIV;
          else                    state_q <= S_RESP;
        end
        S_MEM: begin
          state_q <= S_RESP;
        end
        S_DIV: begin
          if (stat_i.div_done) state_q <= S_RESP;
        end
        S_RESP: begin
          if (cmd_o.out_load) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== design/trm_datapath.sv =====
module trm_datapath #(
  parameter int unsigned INSTR_DEPTH = trm_pkg::INSTR_DEPTH_DEF,
  parameter int unsigned DATA_DEPTH  = trm_pkg::DATA_DEPTH_DEF,
  parameter int unsigned REG_COUNT   = trm_pkg::REG_COUNT_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  trm_pkg::cmd_t                     cmd_i,
  output trm_pkg::stat_t                    stat_o,
  input  logic [trm_pkg::OP_W-1:0]          operation_i,
  input  logic [trm_pkg::REG_W-1:0]         dest_reg_i,
  input  logic [trm_pkg::REG_W-1:0]         src_a_reg_i,
  input  logic [trm_pkg::REG_W-1:0]         src_b_reg_i,
  input  logic [trm_pkg::WORD_W-1:0]        immediate_i,
  input  logic [trm_pkg::WORD_W-1:0]        input_value_i,
  output logic [trm_pkg::PC_OUT_W-1:0]      next_pc_o,
  output logic                              halted_o,
  output logic [trm_pkg::STAT_W-1:0]        status_o,
  output logic                              out_valid_o,
  output logic [trm_pkg::WORD_W-1:0]        out_value_o
);
  localparam int unsigned W   = trm_pkg::WORD_W;
  localparam int unsigned PCW = $clog2(INSTR_DEPTH + 1);
  localparam int unsigned DAW = $clog2(DATA_DEPTH);
  localparam int unsigned RIW = $clog2(REG_COUNT);
  localparam int unsigned AW  = W + 2;

  // latched instruction
  logic [trm_pkg::OP_W-1:0]  op_q;
  logic [trm_pkg::REG_W-1:0] rd_q, ra_q, rb_q;
  logic [W-1:0]              imm_q, inv_q;

  // machine state
  logic [PCW-1:0] pc_q;
  logic           halt_q;

  // register file with per-entry valid bits
  logic [W-1:0]         rf_mem [REG_COUNT];
  logic [REG_COUNT-1:0] rf_vld_q;
  logic [W-1:0]         rd0_q, rd1_q;
  logic                 v0_q, v1_q;
  logic [RIW-1:0]       ra0, ra1, rf_wa;
  logic                 rf_we;
  logic [W-1:0]         rf_wd;
  logic                 in_arith;

  // data memory and clearing pass
  logic [W-1:0]   dmem [DATA_DEPTH];
  logic [W-1:0]   mem_rd_q;
  logic [DAW-1:0] clr_cnt_q, maddr;
  logic           clr_done_q;

  // exec results
  logic [W-1:0]      x, y;
  logic              r_ok, a_ok, b_ok, run;
  logic [AW-1:0]     addr, rel;
  logic              addr_ok, abs_ok, rel_ok;
  logic [PCW-1:0]    ex_npc;
  logic              ex_halt, ex_we, ex_st, ex_mem, ex_div, ex_ov;
  logic [W-1:0]      ex_wd, ex_oval;
  trm_pkg::status_e  ex_st_code, err;

  logic [PCW-1:0]    res_npc_q;
  logic              res_halt_q, res_ov_q;
  logic [trm_pkg::STAT_W-1:0] res_st_q;
  logic [W-1:0]      res_oval_q;

  logic              div_start, div_done;
  logic [W-1:0]      quo;

  // read ports: arithmetic reads a,b; everything else reads r,a
  assign in_arith = (operation_i == trm_pkg::OP_ADD) || (operation_i == trm_pkg::OP_SUB) ||
                    (operation_i == trm_pkg::OP_MUL) || (operation_i == trm_pkg::OP_DIV);
  assign ra0 = in_arith ? RIW'(src_a_reg_i) : RIW'(dest_reg_i);
  assign ra1 = in_arith ? RIW'(src_b_reg_i) : RIW'(src_a_reg_i);

  always_ff @(posedge clk_i) begin
    if (rf_we) rf_mem[rf_wa] <= rf_wd;
    if (cmd_i.capture) begin
      rd0_q <= rf_mem[ra0];
      rd1_q <= rf_mem[ra1];
      op_q  <= operation_i;
      rd_q  <= dest_reg_i;
      ra_q  <= src_a_reg_i;
      rb_q  <= src_b_reg_i;
      imm_q <= immediate_i;
      inv_q <= input_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_vld_q <= '0;
      v0_q     <= 1'b0;
      v1_q     <= 1'b0;
    end else begin
      if (rf_we) rf_vld_q[rf_wa] <= 1'b1;
      if (cmd_i.capture) begin
        v0_q <= rf_vld_q[ra0];
        v1_q <= rf_vld_q[ra1];
      end
    end
  end

  assign x = v0_q ? rd0_q : '0;
  assign y = v1_q ? rd1_q : '0;

  // operand checks and address arithmetic
  assign r_ok    = 32'(rd_q) < REG_COUNT;
  assign a_ok    = 32'(ra_q) < REG_COUNT;
  assign b_ok    = 32'(rb_q) < REG_COUNT;
  assign run     = !halt_q && (32'(pc_q) < INSTR_DEPTH);
  assign addr    = {{2{imm_q[W-1]}}, imm_q} + {{2{y[W-1]}}, y};
  assign addr_ok = !addr[AW-1] && (addr < AW'(DATA_DEPTH));
  assign abs_ok  = !imm_q[W-1] && (imm_q < W'(INSTR_DEPTH));
  assign rel     = AW'(pc_q) + {{2{imm_q[W-1]}}, imm_q} + {{2{y[W-1]}}, y};
  assign rel_ok  = !rel[AW-1] && (rel < AW'(INSTR_DEPTH));
  assign maddr   = addr[DAW-1:0];

  // instruction evaluation
  always_comb begin
    err        = trm_pkg::ST_OK;
    ex_st_code = trm_pkg::ST_OK;
    ex_npc     = pc_q + 1'b1;
    ex_halt    = halt_q;
    ex_we      = 1'b0;
    ex_wd      = '0;
    ex_st      = 1'b0;
    ex_mem     = 1'b0;
    ex_div     = 1'b0;
    ex_ov      = 1'b0;
    ex_oval    = '0;
    case (op_q)
      trm_pkg::OP_HALT: begin
        ex_halt    = 1'b1;
        ex_st_code = trm_pkg::ST_HALT;
      end
      trm_pkg::OP_IN: begin
        if (!r_ok) err = trm_pkg::ST_ADDR;
        else begin ex_we = 1'b1; ex_wd = inv_q; end
      end
      trm_pkg::OP_OUT: begin
        if (!r_ok) err = trm_pkg::ST_ADDR;
        else begin ex_ov = 1'b1; ex_oval = x; end
      end
      trm_pkg::OP_ADD, trm_pkg::OP_SUB, trm_pkg::OP_MUL: begin
        if (!(r_ok && a_ok && b_ok)) err = trm_pkg::ST_ADDR;
        else begin
          ex_we = 1'b1;
          if (op_q == trm_pkg::OP_ADD)      ex_wd = x + y;
          else if (op_q == trm_pkg::OP_SUB) ex_wd = x - y;
          else                              ex_wd = W'(x * y);
        end
      end
      trm_pkg::OP_DIV: begin
        if (!(r_ok && a_ok && b_ok)) err = trm_pkg::ST_ADDR;
        else if (y == '0)            err = trm_pkg::ST_DIV0;
        else                         ex_div = 1'b1;
      end
      trm_pkg::OP_LD, trm_pkg::OP_ST: begin
        if (!(r_ok && a_ok) || !addr_ok) err = trm_pkg::ST_ADDR;
        else if (op_q == trm_pkg::OP_LD) ex_mem = 1'b1;
        else                             ex_st  = 1'b1;
      end
      trm_pkg::OP_LDA, trm_pkg::OP_LDC: begin
        if (!r_ok) err = trm_pkg::ST_ADDR;
        else begin ex_we = 1'b1; ex_wd = imm_q; end
      end
      trm_pkg::OP_JLT, trm_pkg::OP_JLE, trm_pkg::OP_JGE, trm_pkg::OP_JGT: begin
        if (!r_ok)       err = trm_pkg::ST_ADDR;
        else if (!abs_ok) err = trm_pkg::ST_JUMP;
        else if (((op_q == trm_pkg::OP_JLT) && x[W-1]) ||
                 ((op_q == trm_pkg::OP_JLE) && (x[W-1] || x == '0)) ||
                 ((op_q == trm_pkg::OP_JGE) && !x[W-1]) ||
                 ((op_q == trm_pkg::OP_JGT) && !x[W-1] && x != '0))
          ex_npc = PCW'(imm_q);
      end
      trm_pkg::OP_JEQ: begin
        if (!(r_ok && a_ok)) err = trm_pkg::ST_ADDR;
        else if (x == '0) begin
          if (!rel_ok) err = trm_pkg::ST_JUMP;
          else         ex_npc = PCW'(rel);
        end
      end
      trm_pkg::OP_JNE: begin
        if (!(r_ok && a_ok)) err = trm_pkg::ST_ADDR;
        else if (x != y) begin
          if (!abs_ok) err = trm_pkg::ST_JUMP;
          else         ex_npc = PCW'(imm_q);
        end
      end
      trm_pkg::OP_EMPTY: err = trm_pkg::ST_EMPTY;
      default: ;
    endcase
    // error: stop in place, nothing written
    if (err != trm_pkg::ST_OK) begin
      ex_st_code = err;
      ex_npc     = pc_q;
      ex_halt    = 1'b1;
      ex_we      = 1'b0;
      ex_st      = 1'b0;
      ex_mem     = 1'b0;
      ex_div     = 1'b0;
      ex_ov      = 1'b0;
      ex_oval    = '0;
    end
    // stopped or past the end: no change at all
    if (!run) begin
      ex_st_code = trm_pkg::ST_STOPPED;
      ex_npc     = pc_q;
      ex_halt    = halt_q;
      ex_we      = 1'b0;
      ex_st      = 1'b0;
      ex_mem     = 1'b0;
      ex_div     = 1'b0;
      ex_ov      = 1'b0;
      ex_oval    = '0;
    end
  end

  // single register write port
  assign rf_we = (cmd_i.exec && ex_we) || cmd_i.ld_commit || cmd_i.div_commit;
  assign rf_wa = RIW'(rd_q);
  assign rf_wd = cmd_i.ld_commit ? mem_rd_q : (cmd_i.div_commit ? quo : ex_wd);

  // data memory: zero sweep after reset, then one access per exec
  always_ff @(posedge clk_i) begin
    if (!clr_done_q)                dmem[clr_cnt_q] <= '0;
    else if (cmd_i.exec && ex_st)   dmem[maddr] <= x;
    if (cmd_i.exec) mem_rd_q <= dmem[maddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q  <= '0;
      clr_done_q <= 1'b0;
      pc_q       <= '0;
      halt_q     <= 1'b0;
    end else begin
      if (!clr_done_q) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
        if (clr_cnt_q == DAW'(DATA_DEPTH - 1)) clr_done_q <= 1'b1;
      end
      if (cmd_i.exec) begin
        pc_q   <= ex_npc;
        halt_q <= ex_halt;
      end
    end
  end

  // result and output registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      res_npc_q  <= ex_npc;
      res_halt_q <= ex_halt;
      res_st_q   <= ex_st_code;
      res_ov_q   <= ex_ov;
      res_oval_q <= ex_oval;
    end
    if (cmd_i.out_load) begin
      next_pc_o   <= trm_pkg::PC_OUT_W'(res_npc_q);
      halted_o    <= res_halt_q;
      status_o    <= res_st_q;
      out_valid_o <= res_ov_q;
      out_value_o <= res_oval_q;
    end
  end

  assign div_start = cmd_i.exec && ex_div;

  trm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (x),
    .divisor_i  (y),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  assign stat_o.clr_done = clr_done_q;
  assign stat_o.go_mem   = ex_mem;
  assign stat_o.go_div   = ex_div;
  assign stat_o.div_done = div_done;
endmodule

// ===== design/trm_checker.sv =====
module trm_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic                         halted_i,
  input logic [trm_pkg::STAT_W-1:0]   status_i,
  input logic                         res_out_valid_i,
  input logic [trm_pkg::WORD_W-1:0]   res_out_value_i
);
  // a pending result is not dropped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // one instruction in flight: no accept right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("accepted a second instruction back to back");

  // errors and HALT always leave the machine stopped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != trm_pkg::ST_OK && status_i != trm_pkg::ST_STOPPED
      |-> halted_i)
    else $error("stop status without halted");

  // OUT value only on a clean OUT step, zero otherwise
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (res_out_valid_i ? (status_i == trm_pkg::ST_OK && !halted_i)
                                     : (res_out_value_i == '0)))
    else $error("out_value inconsistent with out_valid");
endmodule

bind tiny_register_machine_step_core trm_checker u_trm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_ch.valid),
  .in_ready_i      (in_ch.ready),
  .out_valid_i     (out_ch.valid),
  .out_ready_i     (out_ch.ready),
  .halted_i        (out_ch.halted),
  .status_i        (out_ch.status),
  .res_out_valid_i (out_ch.out_valid),
  .res_out_value_i (out_ch.out_value)
);
